// ===== src/lapf_pkg.sv =====
// lapf_pkg: shared constants and types for the 3x3 Laplacian edge filter.
// No dependencies; imported by lapf_line_store and the core top level.
`timescale 1ns / 1ps

package lapf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4095;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 12;
    // used-width arithmetic must hold both MAX_WIDTH and the register value
    localparam int UW_W       = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic             sel;
        logic [COL_W-1:0] col;
    } line_req_t;

endpackage

// ===== src/lapf_line_store.sv =====
// lapf_line_store: two ping-pong line memories holding the two previous rows.
// Depends on lapf_pkg; returns upper, center and right neighbors, registered.
`timescale 1ns / 1ps

module lapf_line_store (
    input  logic               clk,
    input  lapf_pkg::line_req_t req,
    input  lapf_pkg::pixel_t   wr_data,
    output lapf_pkg::pixel_t   up_px,
    output lapf_pkg::pixel_t   center_px,
    output lapf_pkg::pixel_t   right_px
);
    import lapf_pkg::*;

    pixel_t mem0 [MAX_WIDTH];
    pixel_t mem1 [MAX_WIDTH];

    pixel_t m0a_reg;
    pixel_t m0b_reg;
    pixel_t m1a_reg;
    pixel_t m1b_reg;
    logic   sel_reg;

    logic [COL_W-1:0] col_right;

    assign col_right = req.col + COL_W'(1);

    always_ff @(posedge clk)
    begin
        if (req.wr_en && !req.sel)
        begin
            mem0[req.col] <= wr_data;
        end
        if (req.rd_en)
        begin
            m0a_reg <= mem0[req.col];
            m0b_reg <= mem0[col_right];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en && req.sel)
        begin
            mem1[req.col] <= wr_data;
        end
        if (req.rd_en)
        begin
            m1a_reg <= mem1[req.col];
            m1b_reg <= mem1[col_right];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            sel_reg <= req.sel;
        end
    end

    // sel names the buffer of the current row, which still holds row r-2
    assign up_px     = sel_reg ? m1a_reg : m0a_reg;
    assign center_px = sel_reg ? m0a_reg : m1a_reg;
    assign right_px  = sel_reg ? m0b_reg : m1b_reg;

endmodule

// ===== src/laplacian_edge_filter_3x3_core.sv =====
// laplacian_edge_filter_3x3_core: 3x3 Laplacian over an RGB raster stream.
// Depends on lapf_pkg and lapf_line_store.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------------
//   input    | in_valid / in_ready  | req_type, red_in, green_in, blue_in
//   output   | out_valid / out_ready| red_out, green_out, blue_out, alpha_out,
//            |                      | frame_end
//   config   | APB, pready tied 1   | 0x0 row width, 0x4 frame height
//
// One request per clock unless the output stalls; a result passes the registered
// line-memory read and window-stage registers, then the output register.
// Row 0 gives no results; the frame drains with one flush request per column.
// Reset clears position and valid flags, loads 640x480; line memories are kept.
// in_ready drops only while the output is stalled and the input stage is full.
`timescale 1ns / 1ps

module laplacian_edge_filter_3x3_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic [7:0]  alpha_out,
    output logic        frame_end,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lapf_pkg::*;

    function automatic logic [7:0] lap_chan(
        input logic [7:0] up,
        input logic [7:0] dn,
        input logic [7:0] lf,
        input logic [7:0] rt,
        input logic [7:0] ce
    );
        logic signed [11:0] s;
        begin
            s = $signed({4'b0, up}) + $signed({4'b0, dn}) + $signed({4'b0, lf})
              + $signed({4'b0, rt}) - $signed({2'b0, ce, 2'b0});
            if (s < 0)
            begin
                lap_chan = 8'd0;
            end
            else if (s > 12'sd255)
            begin
                lap_chan = 8'hFF;
            end
            else
            begin
                lap_chan = s[7:0];
            end
        end
    endfunction

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;

    logic       s1_valid_reg;
    pixel_t     s1_dn_reg;
    logic       s1_first_reg;
    logic       s1_right_reg;
    logic       s1_up_reg;
    logic       s1_last_reg;
    pixel_t     left_reg;

    logic       out_valid_reg;
    logic [7:0] red_reg, green_reg, blue_reg;
    logic       frame_end_reg;

    logic [UW_W-1:0]     w_used;
    logic [HEIGHT_W-1:0] h_used;
    logic [COL_W-1:0]    c_eff;
    logic [HEIGHT_W-1:0] r_eff;
    logic [UW_W-1:0]     c_plus;
    logic                col_last;
    logic                accept, pix_ok, flush_ok, emit, load;
    logic                out_free, s1_move, cfg_wr;

    line_req_t lreq;
    pixel_t    in_px, up_px, center_px, right_px;
    pixel_t    up_g, left_g, right_g;

    // register decode
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx_t'(paddr[2]))
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_W'(640);
            height_reg <= HEIGHT_W'(480);
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx_t'(paddr[2]))
                REG_WIDTH:  width_reg  <= pwdata[WIDTH_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[HEIGHT_W-1:0];
                default:    ;
            endcase
        end
    end

    // position tracking
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_used = UW_W'(1);
        end
        else if (UW_W'(width_reg) > UW_W'(MAX_WIDTH))
        begin
            w_used = UW_W'(MAX_WIDTH);
        end
        else
        begin
            w_used = UW_W'(width_reg);
        end
        h_used = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
    end

    always_comb
    begin
        if (UW_W'(col_reg) >= w_used || row_reg > h_used)
        begin
            c_eff = '0;
            r_eff = '0;
        end
        else
        begin
            c_eff = col_reg;
            r_eff = row_reg;
        end
    end

    assign c_plus   = UW_W'(c_eff) + UW_W'(1);
    assign col_last = c_plus >= w_used;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign accept   = in_valid && in_ready;

    assign pix_ok   = !req_type && (r_eff < h_used);
    assign flush_ok = req_type && (r_eff >= h_used);
    assign emit     = (pix_ok && r_eff != '0) || flush_ok;
    assign load     = accept && emit;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_wr)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept && (pix_ok || flush_ok))
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = flush_ok ? '0 : r_eff + HEIGHT_W'(1);
            end
            else
            begin
                col_next = c_plus[COL_W-1:0];
                row_next = r_eff;
            end
        end
        else if (accept)
        begin
            col_next = c_eff;
            row_next = r_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line memories
    assign in_px = '{red: red_in, green: green_in, blue: blue_in};

    assign lreq.wr_en = accept && pix_ok;
    assign lreq.rd_en = load;
    assign lreq.sel   = r_eff[0];
    assign lreq.col   = c_eff;

    lapf_line_store u_lines (
        .clk       (clk),
        .req       (lreq),
        .wr_data   (in_px),
        .up_px     (up_px),
        .center_px (center_px),
        .right_px  (right_px)
    );

    // window stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_dn_reg    <= flush_ok ? pixel_t'('0) : in_px;
            s1_first_reg <= (c_eff == '0);
            s1_right_reg <= !col_last;
            s1_up_reg    <= (r_eff >= HEIGHT_W'(2));
            s1_last_reg  <= flush_ok && col_last;
        end
        if (s1_move)
        begin
            left_reg <= center_px;
        end
    end

    assign up_g    = s1_up_reg    ? up_px    : pixel_t'('0);
    assign left_g  = s1_first_reg ? pixel_t'('0) : left_reg;
    assign right_g = s1_right_reg ? right_px : pixel_t'('0);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            red_reg       <= lap_chan(up_g.red, s1_dn_reg.red, left_g.red,
                                      right_g.red, center_px.red);
            green_reg     <= lap_chan(up_g.green, s1_dn_reg.green, left_g.green,
                                      right_g.green, center_px.green);
            blue_reg      <= lap_chan(up_g.blue, s1_dn_reg.blue, left_g.blue,
                                      right_g.blue, center_px.blue);
            frame_end_reg <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;
    assign alpha_out = 8'hFF;
    assign frame_end = frame_end_reg;

endmodule

// ===== src/lapf_checker.sv =====
// lapf_checker: port-level assertions for laplacian_edge_filter_3x3_core.
// No package dependency; attached to the core by the bind at the end.
`timescale 1ns / 1ps

module lapf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] red_out,
    input logic [7:0] green_out,
    input logic [7:0] blue_out,
    input logic [7:0] alpha_out,
    input logic       frame_end
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_out)
            && $stable(green_out) && $stable(blue_out) && $stable(frame_end))
        else $error("result changed while stalled");

    // a fresh result follows an accepted request
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without matching request");

    // a free output side never blocks the input
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled with output free");

    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> alpha_out == 8'hFF)
        else $error("alpha not opaque");

endmodule

bind laplacian_edge_filter_3x3_core lapf_checker u_lapf_checker (.*);
